// ===== hw/rtl/text_console_character_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Text console character engine: assertion macros
// Shared concurrent assertion forms used by the console top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console character engine package
// Command codes, character codes, sequencer states and the control structs
// passed between the cursor unit, the screen store and the top level.
// ----------------------------------------------------------------------------
package tcce_pkg;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GOTO  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_SCROLL
    } store_state_t;

    // request to the screen store, valid for one cycle
    typedef struct packed {
        logic        wr;
        logic        rd;
        logic        fill;
        logic        scroll;
        logic [15:0] wdata;
        logic [7:0]  fill_attr;
    } store_req_t;

    // what a put-character does to the store
    typedef struct packed {
        logic write;
        logic scroll;
    } put_stat_t;

endpackage

// ===== hw/rtl/tcce_cursor.sv =====
// ----------------------------------------------------------------------------
// Text console cursor unit
// Holds the cursor and works out its next position for put, go-to and clear.
// ----------------------------------------------------------------------------
module tcce_cursor #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8,
    localparam int CW  = $clog2(COLUMNS),
    localparam int RW  = $clog2(ROWS),
    localparam int AW  = $clog2(COLUMNS * ROWS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                apply,
    input  tcce_pkg::cmd_t      cmd,
    input  logic [7:0]          char_code,
    input  logic [6:0]          col,
    input  logic [4:0]          row,
    output logic [CW-1:0]       cur_col,
    output logic [RW-1:0]       cur_row,
    output logic [AW-1:0]       cur_loc,
    output tcce_pkg::put_stat_t put_stat
);

    localparam int NCW = $clog2(COLUMNS + TAB_WIDTH);
    localparam logic [7:0] COLS_LIM = 8'(COLUMNS);
    localparam logic [6:0] ROWS_LIM = 7'(ROWS);

    logic [CW-1:0]  cur_col_reg, cur_col_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [NCW-1:0] tab_stop [COLUMNS];
    logic [CW-1:0]  put_col;
    logic [RW-1:0]  put_row;

    // next tab stop for every column
    for (genvar c = 0; c < COLUMNS; c++) begin : g_tab
        assign tab_stop[c] = NCW'((c / TAB_WIDTH + 1) * TAB_WIDTH);
    end

    always_comb begin
        logic [NCW-1:0] pc;
        logic [RW:0]    pr;
        pc = NCW'(cur_col_reg);
        pr = (RW+1)'(cur_row_reg);
        put_stat = '0;
        priority if (char_code == tcce_pkg::CH_BS) begin
            if (cur_col_reg != '0) begin
                pc = NCW'(cur_col_reg - CW'(1));
            end
        end else if (char_code == tcce_pkg::CH_TAB) begin
            pc = tab_stop[cur_col_reg];
        end else if (char_code == tcce_pkg::CH_CR) begin
            pc = '0;
        end else if (char_code == tcce_pkg::CH_LF) begin
            pc = '0;
            pr = pr + (RW+1)'(1);
        end else if (char_code >= tcce_pkg::CH_SPACE) begin
            put_stat.write = 1'b1;
            pc = NCW'(cur_col_reg) + NCW'(1);
        end else begin
            pc = NCW'(cur_col_reg);
        end
        // wrap
        if (pc >= NCW'(COLUMNS)) begin
            pc = '0;
            pr = pr + (RW+1)'(1);
        end
        // scroll at the bottom
        if (pr >= (RW+1)'(ROWS)) begin
            put_stat.scroll = 1'b1;
            pr = (RW+1)'(ROWS - 1);
        end
        put_col = CW'(pc);
        put_row = RW'(pr);
    end

    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (apply) begin
            unique case (cmd)
                tcce_pkg::CMD_PUT: begin
                    cur_col_next = put_col;
                    cur_row_next = put_row;
                end
                tcce_pkg::CMD_GOTO: begin
                    if ({1'b0, col} < COLS_LIM) begin
                        cur_col_next = CW'(col);
                    end
                    if ({2'b0, row} < ROWS_LIM) begin
                        cur_row_next = RW'(row);
                    end
                end
                tcce_pkg::CMD_CLEAR: begin
                    cur_col_next = '0;
                    cur_row_next = '0;
                end
                tcce_pkg::CMD_READ: begin
                    cur_col_next = cur_col_reg;
                    cur_row_next = cur_row_reg;
                end
                default: begin
                    cur_col_next = cur_col_reg;
                    cur_row_next = cur_row_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end else begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    assign cur_col = cur_col_reg;
    assign cur_row = cur_row_reg;
    assign cur_loc = AW'(cur_row_reg) * AW'(COLUMNS) + AW'(cur_col_reg);

endmodule

// ===== hw/rtl/tcce_store.sv =====
// ----------------------------------------------------------------------------
// Text console screen store
// Cell memory with a sweep sequencer: one address counter walks the store
// for the reset clear, the clear-screen fill and the one-row scroll.
// ----------------------------------------------------------------------------
module tcce_store #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int AW     = $clog2(CELLS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcce_pkg::store_req_t req,
    input  logic [AW-1:0]        addr,
    output logic                 ready,
    output logic [15:0]          rd_data
);

    localparam int COPY_CELLS = CELLS - COLUMNS;

    tcce_pkg::store_state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [15:0]   fill_reg, fill_next;
    logic [15:0]   rd_data_reg;
    logic [15:0]   cell_mem [CELLS];

    logic          idx_last;
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;

    assign idx_last = (idx_reg == AW'(CELLS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcce_pkg::ST_INIT: begin
                if (idx_last) state_next = tcce_pkg::ST_IDLE;
            end
            tcce_pkg::ST_IDLE: begin
                if (req.fill) begin
                    state_next = tcce_pkg::ST_FILL;
                end else if (req.scroll) begin
                    state_next = tcce_pkg::ST_SCROLL;
                end
            end
            tcce_pkg::ST_FILL, tcce_pkg::ST_SCROLL: begin
                if (idx_last) state_next = tcce_pkg::ST_IDLE;
            end
            default: state_next = tcce_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory port control
    always_comb begin
        ready     = 1'b0;
        we        = 1'b0;
        waddr     = idx_reg;
        wdata     = '0;
        re        = 1'b0;
        raddr     = addr;
        idx_next  = idx_reg;
        fill_next = fill_reg;
        unique case (state_reg)
            tcce_pkg::ST_INIT: begin
                we       = 1'b1;
                idx_next = idx_last ? '0 : idx_reg + AW'(1);
            end
            tcce_pkg::ST_IDLE: begin
                ready = 1'b1;
                we    = req.wr;
                waddr = addr;
                wdata = req.wdata;
                re    = req.rd;
                if (req.fill || req.scroll) begin
                    fill_next = {req.fill_attr, tcce_pkg::CH_SPACE};
                end
                // prefetch the first cell to move up
                if (req.scroll) begin
                    re    = 1'b1;
                    raddr = AW'(COLUMNS);
                end
            end
            tcce_pkg::ST_FILL: begin
                we       = 1'b1;
                wdata    = fill_reg;
                idx_next = idx_last ? '0 : idx_reg + AW'(1);
            end
            tcce_pkg::ST_SCROLL: begin
                we       = 1'b1;
                wdata    = (idx_reg < AW'(COPY_CELLS)) ? rd_data_reg : fill_reg;
                // fetch the source of the next cell one row below
                re       = (idx_reg < AW'(COPY_CELLS - 1));
                raddr    = idx_reg + AW'(COLUMNS + 1);
                idx_next = idx_last ? '0 : idx_reg + AW'(1);
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcce_pkg::ST_INIT;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_reg <= fill_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            cell_mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= cell_mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/text_console_character_engine.sv =====
// ----------------------------------------------------------------------------
// Text console character engine
// Text-mode screen store and cursor driven by put, go-to, clear and read items.
// ----------------------------------------------------------------------------
// After reset the block clears every cell of the screen store to zero with
// s_tready low; configuration writes are taken during that time. A
// put-character without scroll, a go-to or a read-cell passes from
// acceptance through the pending flag into the output register. Clear-screen
// and a put-character that scrolls wait for a sweep as well: one sweep
// counter walks every cell through the single write port of the store, one
// cell per cycle. One item is in work at a time; the next is accepted once the
// result has moved into the output register, even while that result waits.
module text_console_character_engine #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // text_color
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // char_code[7:0], col[14:8], row[19:15],
                                       // clear_attr[27:20], zero[31:28]
    input  logic [1:0]  s_tuser,       // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // cursor_col[6:0], cursor_row[11:7],
                                       // cursor_location[22:12],
                                       // cell_data[38:23], zero[39]
);

    `include "text_console_character_engine_macros.svh"

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = $clog2(COLUMNS * ROWS);
    localparam logic [7:0] COLS_LIM = 8'(COLUMNS);
    localparam logic [6:0] ROWS_LIM = 7'(ROWS);

    tcce_pkg::cmd_t       in_cmd;
    logic [7:0]           in_char;
    logic [6:0]           in_col;
    logic [4:0]           in_row;
    logic [7:0]           in_attr;

    logic [7:0]           text_color_reg;
    logic                 resp_pend_reg, resp_pend_next;
    logic                 cell_ok_reg, cell_ok_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [39:0]          m_tdata_reg, m_tdata_next;

    logic                 accept;
    logic                 out_load;
    logic                 read_ok;
    logic [AW-1:0]        read_addr;
    logic [CW-1:0]        cur_col;
    logic [RW-1:0]        cur_row;
    logic [AW-1:0]        cur_loc;
    tcce_pkg::put_stat_t  put_stat;
    tcce_pkg::store_req_t store_req;
    logic [AW-1:0]        store_addr;
    logic                 store_ready;
    logic [15:0]          store_rd_data;
    logic [15:0]          cell_out;

    assign in_cmd  = tcce_pkg::cmd_t'(s_tuser);
    assign in_char = s_tdata[7:0];
    assign in_col  = s_tdata[14:8];
    assign in_row  = s_tdata[19:15];
    assign in_attr = s_tdata[27:20];

    assign s_tready = store_ready && !resp_pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_load = resp_pend_reg && store_ready && (!m_tvalid_reg || m_tready);

    assign read_ok   = ({1'b0, in_col} < COLS_LIM) && ({2'b0, in_row} < ROWS_LIM);
    assign read_addr = AW'(in_row) * AW'(COLUMNS) + AW'(in_col);

    tcce_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .apply     (accept),
        .cmd       (in_cmd),
        .char_code (in_char),
        .col       (in_col),
        .row       (in_row),
        .cur_col   (cur_col),
        .cur_row   (cur_row),
        .cur_loc   (cur_loc),
        .put_stat  (put_stat)
    );

    // store request for the accepted item
    always_comb begin
        store_req  = '0;
        store_addr = cur_loc;
        if (accept) begin
            unique case (in_cmd)
                tcce_pkg::CMD_PUT: begin
                    store_req.wr        = put_stat.write;
                    store_req.wdata     = {text_color_reg, in_char};
                    store_req.scroll    = put_stat.scroll;
                    store_req.fill_attr = text_color_reg;
                end
                tcce_pkg::CMD_GOTO: begin
                    store_req = '0;
                end
                tcce_pkg::CMD_CLEAR: begin
                    store_req.fill      = 1'b1;
                    store_req.fill_attr = in_attr;
                end
                tcce_pkg::CMD_READ: begin
                    store_req.rd = read_ok;
                    store_addr   = read_addr;
                end
                default: store_req = '0;
            endcase
        end
    end

    tcce_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .addr    (store_addr),
        .ready   (store_ready),
        .rd_data (store_rd_data)
    );

    assign cell_out = cell_ok_reg ? store_rd_data : 16'h0000;

    always_comb begin
        resp_pend_next = resp_pend_reg;
        cell_ok_next   = cell_ok_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            resp_pend_next = 1'b0;
            m_tvalid_next  = 1'b1;
            m_tdata_next   = {1'b0, cell_out, 11'(cur_loc), 5'(cur_row), 7'(cur_col)};
        end
        if (accept) begin
            resp_pend_next = 1'b1;
            cell_ok_next   = (in_cmd == tcce_pkg::CMD_READ) && read_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= '0;
            resp_pend_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                text_color_reg <= cfg_wr_data;
            end
            resp_pend_reg <= resp_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cell_ok_reg <= cell_ok_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TCCE_ASSERT_NEXT(a_accept_holds_off, aclk, aresetn, accept,
        resp_pend_reg && !s_tready, "item accepted while a result is pending")
    `TCCE_ASSERT_SAME(a_cursor_range, aclk, aresetn, 1'b1,
        (32'(cur_col) < COLUMNS) && (32'(cur_row) < ROWS), "cursor out of screen")
    `TCCE_ASSERT_NEXT(a_result_loaded, aclk, aresetn, out_load,
        m_tvalid && !resp_pend_reg, "result not presented after load")

endmodule
